[rtl/sefg_pkg.sv]
package sefg_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int RESULT_LIMIT = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [31:0] DISK_SECTORS_RESET = 32'd2097152;
	localparam logic [31:0] RESERVED_END_RESET = 32'd12;

	localparam logic [CFG_IDX_W-1:0] REG_DISK_SECTORS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED_END = 2'd1;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_LIST = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_GAP = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic [1:0] operation;
		logic [31:0] sector_key;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] gap_start;
		logic [31:0] gap_end;
		logic last;
	} out_item_t;

	typedef enum logic [1:0] {
		RD_OFF,
		RD_J_MINUS,
		RD_I,
		RD_I_NEXT
	} rd_sel_t;

	typedef enum logic [2:0] {
		WR_OFF,
		WR_ZERO,
		WR_BOUND_RST,
		WR_BOUND,
		WR_SHIFT,
		WR_KEY
	} wr_sel_t;

	typedef enum logic [2:0] {
		PU_IDLE,
		PU_OK,
		PU_FULL,
		PU_EMPTY,
		PU_MID,
		PU_LAST
	} push_t;

	typedef enum logic [3:0] {
		S_INIT_LO,
		S_INIT_HI,
		S_IDLE,
		S_CLR_LO,
		S_CLR_HI,
		S_INS_RD,
		S_INS_CMP,
		S_INS_PUT,
		S_LST_RD,
		S_LST_E,
		S_LST_P,
		S_LST_END,
		S_RESP_OK,
		S_RESP_FULL
	} state_t;

	typedef struct packed {
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		push_t push;
		logic load_key;
		logic list_start;
		logic j_dec;
		logic count_inc;
		logic count_two;
		logic take_gap;
		logic ptr_load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
		logic full;
		logic j_zero;
		logic shift;
		logic i_end;
		logic next_end;
		logic gap;
		logic have_pend;
		logic n_last;
	} sts_t;

endpackage

[rtl/sefg_ctrl.sv]
module sefg_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [1:0] operation,
	input sefg_pkg::sts_t sts,
	output logic in_stall,
	output sefg_pkg::cmd_t cmd
);

	sefg_pkg::state_t state_q, state_next;
	logic accept;

	assign in_stall = (state_q != sefg_pkg::S_IDLE);
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sefg_pkg::S_INIT_LO;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sefg_pkg::S_INIT_LO: state_next = sefg_pkg::S_INIT_HI;
			sefg_pkg::S_INIT_HI: state_next = sefg_pkg::S_IDLE;
			sefg_pkg::S_IDLE: begin
				if (accept) begin
					case (operation)
						sefg_pkg::OP_INSERT: state_next = sts.full ?
							sefg_pkg::S_RESP_FULL : sefg_pkg::S_INS_RD;
						sefg_pkg::OP_LIST: state_next = sefg_pkg::S_LST_RD;
						sefg_pkg::OP_CLEAR: state_next = sefg_pkg::S_CLR_LO;
						default: state_next = sefg_pkg::S_RESP_OK;
					endcase
				end
			end
			sefg_pkg::S_CLR_LO: state_next = sefg_pkg::S_CLR_HI;
			sefg_pkg::S_CLR_HI: state_next = sefg_pkg::S_RESP_OK;
			sefg_pkg::S_INS_RD: state_next = sts.j_zero ?
				sefg_pkg::S_INS_PUT : sefg_pkg::S_INS_CMP;
			sefg_pkg::S_INS_CMP: state_next = sts.shift ?
				sefg_pkg::S_INS_RD : sefg_pkg::S_INS_PUT;
			sefg_pkg::S_INS_PUT: state_next = sefg_pkg::S_RESP_OK;
			sefg_pkg::S_LST_RD: state_next = sts.i_end ?
				sefg_pkg::S_LST_END : sefg_pkg::S_LST_E;
			sefg_pkg::S_LST_E: begin
				if (!(sts.gap && sts.have_pend && !sts.out_free)) begin
					if ((sts.gap && sts.n_last) || sts.next_end) begin
						state_next = sefg_pkg::S_LST_END;
					end else begin
						state_next = sefg_pkg::S_LST_P;
					end
				end
			end
			sefg_pkg::S_LST_P: state_next = sefg_pkg::S_LST_RD;
			sefg_pkg::S_LST_END,
			sefg_pkg::S_RESP_OK,
			sefg_pkg::S_RESP_FULL: begin
				if (sts.out_free) begin
					state_next = sefg_pkg::S_IDLE;
				end
			end
			default: state_next = sefg_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = sefg_pkg::RD_OFF;
		cmd.wr_sel = sefg_pkg::WR_OFF;
		cmd.push = sefg_pkg::PU_IDLE;
		case (state_q)
			sefg_pkg::S_INIT_LO: cmd.wr_sel = sefg_pkg::WR_ZERO;
			sefg_pkg::S_INIT_HI: cmd.wr_sel = sefg_pkg::WR_BOUND_RST;
			sefg_pkg::S_IDLE: begin
				cmd.load_key = accept && (operation == sefg_pkg::OP_INSERT);
				cmd.list_start = accept && (operation == sefg_pkg::OP_LIST);
			end
			sefg_pkg::S_CLR_LO: cmd.wr_sel = sefg_pkg::WR_ZERO;
			sefg_pkg::S_CLR_HI: begin
				cmd.wr_sel = sefg_pkg::WR_BOUND;
				cmd.count_two = 1'b1;
			end
			sefg_pkg::S_INS_RD: begin
				if (!sts.j_zero) begin
					cmd.rd_sel = sefg_pkg::RD_J_MINUS;
				end
			end
			sefg_pkg::S_INS_CMP: begin
				if (sts.shift) begin
					cmd.wr_sel = sefg_pkg::WR_SHIFT;
					cmd.j_dec = 1'b1;
				end
			end
			sefg_pkg::S_INS_PUT: begin
				cmd.wr_sel = sefg_pkg::WR_KEY;
				cmd.count_inc = 1'b1;
			end
			sefg_pkg::S_LST_RD: begin
				if (!sts.i_end) begin
					cmd.rd_sel = sefg_pkg::RD_I;
				end
			end
			sefg_pkg::S_LST_E: begin
				if (!(sts.gap && sts.have_pend && !sts.out_free)) begin
					if (sts.gap) begin
						cmd.take_gap = 1'b1;
						if (sts.have_pend) begin
							cmd.push = sefg_pkg::PU_MID;
						end
					end
					if (!((sts.gap && sts.n_last) || sts.next_end)) begin
						cmd.rd_sel = sefg_pkg::RD_I_NEXT;
					end
				end
			end
			sefg_pkg::S_LST_P: cmd.ptr_load = 1'b1;
			sefg_pkg::S_LST_END: begin
				if (sts.out_free) begin
					cmd.push = sts.have_pend ? sefg_pkg::PU_LAST : sefg_pkg::PU_EMPTY;
				end
			end
			sefg_pkg::S_RESP_OK: begin
				if (sts.out_free) begin
					cmd.push = sefg_pkg::PU_OK;
				end
			end
			sefg_pkg::S_RESP_FULL: begin
				if (sts.out_free) begin
					cmd.push = sefg_pkg::PU_FULL;
				end
			end
			default: cmd.push = sefg_pkg::PU_IDLE;
		endcase
	end

endmodule

[rtl/sefg_dp.sv]
module sefg_dp #(
	parameter int TABLE_DEPTH = sefg_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sefg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input sefg_pkg::in_item_t in_data,
	input sefg_pkg::cmd_t cmd,
	input logic out_stall,
	output sefg_pkg::sts_t sts,
	output logic out_valid,
	output sefg_pkg::out_item_t out_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = $clog2(TABLE_DEPTH + 2);
	localparam int NW = $clog2(sefg_pkg::RESULT_LIMIT + 1);

	logic [31:0] mem [TABLE_DEPTH];

	logic [31:0] disk_sectors_q;
	logic [31:0] reserved_end_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] j_q;
	logic [31:0] key_q;
	logic [IW-1:0] i_q;
	logic [31:0] ptr_q;
	logic [NW-1:0] n_q;
	logic have_pend_q;
	logic [31:0] pend_start_q;
	logic [31:0] pend_end_q;
	logic [31:0] rdata_q;
	logic out_valid_q;
	sefg_pkg::out_item_t out_data_q;

	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	logic [31:0] wr_data;
	logic [32:0] ptr_next;
	logic gap;
	logic out_free;
	sefg_pkg::out_item_t push_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_sectors_q <= sefg_pkg::DISK_SECTORS_RESET;
			reserved_end_q <= sefg_pkg::RESERVED_END_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				sefg_pkg::REG_DISK_SECTORS: disk_sectors_q <= cfg_data;
				sefg_pkg::REG_RESERVED_END: reserved_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			sefg_pkg::RD_J_MINUS: rd_addr = AW'(j_q - CW'(1));
			sefg_pkg::RD_I: rd_addr = AW'(i_q);
			sefg_pkg::RD_I_NEXT: rd_addr = AW'(i_q + IW'(1));
			default: rd_addr = '0;
		endcase
	end
	assign rd_en = (cmd.rd_sel != sefg_pkg::RD_OFF);

	always_comb begin
		wr_addr = AW'(j_q);
		wr_data = key_q;
		case (cmd.wr_sel)
			sefg_pkg::WR_ZERO: begin
				wr_addr = '0;
				wr_data = '0;
			end
			sefg_pkg::WR_BOUND_RST: begin
				wr_addr = AW'(1);
				wr_data = sefg_pkg::DISK_SECTORS_RESET - 32'd1;
			end
			sefg_pkg::WR_BOUND: begin
				wr_addr = AW'(1);
				wr_data = disk_sectors_q - 32'd1;
			end
			sefg_pkg::WR_SHIFT: wr_data = rdata_q;
			default: wr_data = key_q;
		endcase
	end
	assign wr_en = (cmd.wr_sel != sefg_pkg::WR_OFF);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CW'(2);
			j_q <= '0;
			i_q <= '0;
			n_q <= '0;
			have_pend_q <= 1'b0;
		end else begin
			if (cmd.count_two) begin
				count_q <= CW'(2);
			end else if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.load_key) begin
				j_q <= count_q;
			end else if (cmd.j_dec) begin
				j_q <= j_q - CW'(1);
			end
			if (cmd.list_start) begin
				i_q <= IW'(1);
				n_q <= '0;
				have_pend_q <= 1'b0;
			end else begin
				if (cmd.ptr_load) begin
					i_q <= i_q + IW'(2);
				end
				if (cmd.take_gap) begin
					n_q <= n_q + NW'(1);
					have_pend_q <= 1'b1;
				end
			end
		end
	end

	assign ptr_next = {1'b0, ptr_q} + 33'd1;
	assign gap = ({1'b0, rdata_q} > ptr_next);

	always_ff @(posedge clk) begin
		if (cmd.load_key) begin
			key_q <= in_data.sector_key;
		end
		if (cmd.list_start) begin
			ptr_q <= reserved_end_q;
		end else if (cmd.ptr_load) begin
			ptr_q <= rdata_q;
		end
		if (cmd.take_gap) begin
			pend_start_q <= ptr_next[31:0];
			pend_end_q <= rdata_q - 32'd1;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		push_item = '0;
		push_item.last = 1'b1;
		case (cmd.push)
			sefg_pkg::PU_OK: push_item.status = sefg_pkg::ST_OK;
			sefg_pkg::PU_FULL: push_item.status = sefg_pkg::ST_FULL;
			sefg_pkg::PU_EMPTY: push_item.status = sefg_pkg::ST_NONE;
			sefg_pkg::PU_MID, sefg_pkg::PU_LAST: begin
				push_item.status = sefg_pkg::ST_GAP;
				push_item.gap_start = pend_start_q;
				push_item.gap_end = pend_end_q;
				push_item.last = (cmd.push == sefg_pkg::PU_LAST);
			end
			default: push_item.status = sefg_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push != sefg_pkg::PU_IDLE) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push != sefg_pkg::PU_IDLE) begin
			out_data_q <= push_item;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	assign sts.out_free = out_free;
	assign sts.full = (count_q >= CW'(TABLE_DEPTH));
	assign sts.j_zero = (j_q == '0);
	assign sts.shift = (rdata_q >= key_q);
	assign sts.i_end = (i_q >= IW'(count_q));
	assign sts.next_end = ((i_q + IW'(1)) >= IW'(count_q));
	assign sts.gap = gap;
	assign sts.have_pend = have_pend_q;
	assign sts.n_last = (n_q == NW'(sefg_pkg::RESULT_LIMIT - 1));

endmodule

[rtl/sorted_extent_gap_finder_top.sv]
// Sorted sector-boundary table with free-gap listing. The table lives in a
// single-port-write, registered-read memory of TABLE_DEPTH words; after reset
// the block writes the default bounds (INIT_LO, then INIT_HI) before it takes
// its first transfer. Insert walks down from the top entry, moving one entry per
// step (read, then compare and write); a full table is answered with a full
// status and left unchanged. Clear writes the two default bounds again. List
// reads the table through the same port, an odd entry and the one after it per
// step, and reports at most 32 gaps. Each gap result is held back until the next
// one is found, so the last flag is exact. One item is worked at a time; results
// leave through an output register and a stalled output holds the walk.
module sorted_extent_gap_finder_top #(
	parameter int TABLE_DEPTH = sefg_pkg::TABLE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [sefg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [31:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input sefg_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output sefg_pkg::out_item_t out_data
);

	sefg_pkg::cmd_t cmd;
	sefg_pkg::sts_t sts;

	sefg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.operation(in_data.operation),
		.sts(sts),
		.in_stall(in_stall),
		.cmd(cmd)
	);

	sefg_dp #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_data(in_data),
		.cmd(cmd),
		.out_stall(out_stall),
		.sts(sts),
		.out_valid(out_valid),
		.out_data(out_data)
	);

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while previous item still in progress");

	a_push_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push != sefg_pkg::PU_IDLE) |-> sts.out_free)
		else $error("result pushed over a stalled output");

	a_no_insert_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_inc |-> !sts.full)
		else $error("entry count grown past table depth");

	a_pending_flushed: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_gap && sts.have_pend |-> (cmd.push == sefg_pkg::PU_MID))
		else $error("pending gap overwritten without transfer");

endmodule

[dv/tb_sorted_extent_gap_finder_top.sv]
module tb_sorted_extent_gap_finder_top;

	localparam int DEPTH = sefg_pkg::TABLE_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [sefg_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [sefg_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [sefg_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	sefg_pkg::in_item_t in_data;
	logic out_valid;
	logic out_stall;
	sefg_pkg::out_item_t out_data;

	logic [31:0] bounds [DEPTH];
	int unsigned bound_count;
	logic [31:0] disk_size;
	logic [31:0] resv_end;
	sefg_pkg::out_item_t table_replies[$];

	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	bit sender_quiet = 1'b0;
	bit drain_quiet = 1'b0;
	bit hold_req = 1'b0;

	sorted_extent_gap_finder_top u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic int unsigned pick_span();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void reset_bounds();
		foreach (bounds[k])
			bounds[k] = '0;
		bounds[1] = disk_size - 32'd1;
		bound_count = 2;
	endfunction

	function automatic void apply_table_op(sefg_pkg::in_item_t it);
		sefg_pkg::out_item_t r;
		sefg_pkg::out_item_t found[$];
		logic [31:0] ptr;
		logic [31:0] e;
		int unsigned pos;
		int unsigned i;
		r = '0;
		r.status = sefg_pkg::ST_OK;
		r.last = 1'b1;
		case (it.operation)
			sefg_pkg::OP_INSERT: begin
				if (bound_count >= DEPTH) begin
					r.status = sefg_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < bound_count && bounds[pos] < it.sector_key)
						pos++;
					for (i = bound_count; i > pos; i--)
						bounds[i] = bounds[i - 1];
					bounds[pos] = it.sector_key;
					bound_count++;
				end
				table_replies = {table_replies, r};
			end
			sefg_pkg::OP_LIST: begin
				ptr = resv_end;
				for (i = 1; i < bound_count && found.size() < sefg_pkg::RESULT_LIMIT;
						i += 2) begin
					e = bounds[i];
					if ({1'b0, e} > {1'b0, ptr} + 33'd1) begin
						r.status = sefg_pkg::ST_GAP;
						r.gap_start = ptr + 32'd1;
						r.gap_end = e - 32'd1;
						r.last = 1'b0;
						found = {found, r};
					end
					if (i + 1 >= bound_count)
						break;
					ptr = bounds[i + 1];
				end
				if (found.size() == 0) begin
					r = '0;
					r.status = sefg_pkg::ST_NONE;
					r.last = 1'b1;
					table_replies = {table_replies, r};
				end else begin
					found[found.size() - 1].last = 1'b1;
					table_replies = {table_replies, found};
				end
			end
			sefg_pkg::OP_CLEAR: begin
				reset_bounds();
				table_replies = {table_replies, r};
			end
			default: begin
				table_replies = {table_replies, r};
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin
		sefg_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (table_replies.size() == 0) begin
				report_mismatch("unexpected transfer", 32'(out_data.status), '0);
			end else begin
				want = table_replies.pop_front();
				if (out_data.status !== want.status)
					report_mismatch("status", 32'(out_data.status), 32'(want.status));
				if (out_data.gap_start !== want.gap_start)
					report_mismatch("gap_start", out_data.gap_start, want.gap_start);
				if (out_data.gap_end !== want.gap_end)
					report_mismatch("gap_end", out_data.gap_end, want.gap_end);
				if (out_data.last !== want.last)
					report_mismatch("last", 32'(out_data.last), 32'(want.last));
			end
		end
	end

	initial begin
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!drain_quiet && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				n = pick_span();
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_op(input logic [1:0] op, input logic [31:0] key);
		sefg_pkg::in_item_t it;
		int unsigned gap;
		it.operation = op;
		it.sector_key = key;
		gap = 0;
		if (!sender_quiet && $urandom_range(0, 99) >= 55)
			gap = pick_span();
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		apply_table_op(it);
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (table_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [sefg_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sefg_pkg::REG_DISK_SECTORS: disk_size = val;
			sefg_pkg::REG_RESERVED_END: resv_end = val;
			default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_key();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, disk_size);
		return $urandom();
	endfunction

	task automatic test_reset_defaults();
		send_op(sefg_pkg::OP_LIST, '0);
		send_op(OP_SPARE, 32'hA5A5_5A5A);
		send_op(sefg_pkg::OP_LIST, 32'h5A5A_A5A5);
	endtask

	task automatic test_insert_order();
		send_op(sefg_pkg::OP_INSERT, 32'd0);
		send_op(sefg_pkg::OP_INSERT, 32'd0);
		send_op(sefg_pkg::OP_INSERT, 32'hFFFF_FFFF);
		send_op(sefg_pkg::OP_INSERT, 32'd100);
		send_op(sefg_pkg::OP_INSERT, 32'd200);
		send_op(sefg_pkg::OP_INSERT, 32'd100);
		send_op(sefg_pkg::OP_LIST, '0);
		send_op(sefg_pkg::OP_CLEAR, 32'hFFFF_FFFF);
		send_op(sefg_pkg::OP_LIST, '0);
	endtask

	task automatic test_register_extremes();
		settle();
		write_reg(sefg_pkg::REG_RESERVED_END, 32'd0);
		write_reg(sefg_pkg::REG_DISK_SECTORS, 32'd0);
		write_reg(REG_SPARE_LO, $urandom());
		write_reg(REG_SPARE_HI, $urandom());
		send_op(sefg_pkg::OP_CLEAR, '0);
		send_op(sefg_pkg::OP_LIST, '0);
		settle();
		write_reg(sefg_pkg::REG_RESERVED_END, 32'hFFFF_FFFF);
		send_op(sefg_pkg::OP_LIST, '0);
		settle();
		write_reg(sefg_pkg::REG_DISK_SECTORS, 32'd1);
		send_op(sefg_pkg::OP_CLEAR, '0);
		send_op(sefg_pkg::OP_LIST, '0);
		send_op(sefg_pkg::OP_INSERT, 32'hFFFF_FFFF);
		send_op(sefg_pkg::OP_INSERT, 32'd5);
		send_op(sefg_pkg::OP_LIST, '0);
	endtask

	task automatic test_random_traffic();
		int unsigned r;
		for (int round = 0; round < 3; round++) begin
			settle();
			case (round)
				0: write_reg(sefg_pkg::REG_DISK_SECTORS, $urandom_range(1, 32'hFFFF_FFFF));
				1: write_reg(sefg_pkg::REG_DISK_SECTORS, $urandom_range(1, 4096));
				default: write_reg(sefg_pkg::REG_DISK_SECTORS, 32'hFFFF_FFFF);
			endcase
			write_reg(sefg_pkg::REG_RESERVED_END, $urandom_range(0, disk_size >> 4));
			sender_quiet = (round == 1);
			drain_quiet = (round == 1);
			send_op(sefg_pkg::OP_CLEAR, $urandom());
			for (int k = 0; k < 6; k++) begin
				r = $urandom_range(0, 99);
				if (r < 60)
					send_op(sefg_pkg::OP_INSERT, pick_key());
				else if (r < 85)
					send_op(sefg_pkg::OP_LIST, $urandom());
				else if (r < 93)
					send_op(sefg_pkg::OP_CLEAR, $urandom());
				else
					send_op(OP_SPARE, $urandom());
			end
		end
		sender_quiet = 1'b0;
		drain_quiet = 1'b0;
	endtask

	task automatic test_fill_to_full();
		settle();
		write_reg(sefg_pkg::REG_DISK_SECTORS, $urandom_range(32'h1000_0000, 32'hFFFF_FFFF));
		write_reg(sefg_pkg::REG_RESERVED_END, $urandom_range(0, 255));
		send_op(sefg_pkg::OP_CLEAR, '0);
		sender_quiet = 1'b1;
		hold_req = 1'b1;
		for (int k = 0; k < DEPTH - 2; k++)
			send_op(sefg_pkg::OP_INSERT, pick_key());
		sender_quiet = 1'b0;
		for (int k = 0; k < 3; k++)
			send_op(sefg_pkg::OP_INSERT, $urandom());
		send_op(sefg_pkg::OP_LIST, '0);
		send_op(sefg_pkg::OP_CLEAR, '0);
		send_op(sefg_pkg::OP_LIST, '0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		disk_size = sefg_pkg::DISK_SECTORS_RESET;
		resv_end = sefg_pkg::RESERVED_END_RESET;
		reset_bounds();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_insert_order();
		test_register_extremes();
		test_random_traffic();
		test_fill_to_full();

		settle();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
